>>> hw/rtl/pie_pkg.sv
// pie_pkg: shared types, constants and error codes for the postfix evaluator.
// No dependencies.
`default_nettype none
package pie_pkg;
	localparam int STACK_DEPTH = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int DCNT_W = $clog2(VALUE_WIDTH + 1);

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_CHAR = 3'd1;
	localparam logic [2:0] ERR_UNDER = 3'd2;
	localparam logic [2:0] ERR_LEFT = 3'd3;
	localparam logic [2:0] ERR_EMPTY = 3'd4;
	localparam logic [2:0] ERR_DIVZ = 3'd5;
	localparam logic [2:0] ERR_FULL = 3'd6;
	localparam logic [2:0] ERR_LIT = 3'd7;

	// character classes
	localparam logic [2:0] CC_DIGIT = 3'd0;
	localparam logic [2:0] CC_SPACE = 3'd1;
	localparam logic [2:0] CC_ADD = 3'd2;
	localparam logic [2:0] CC_SUB = 3'd3;
	localparam logic [2:0] CC_MUL = 3'd4;
	localparam logic [2:0] CC_DIV = 3'd5;
	localparam logic [2:0] CC_MOD = 3'd6;
	localparam logic [2:0] CC_BAD = 3'd7;

	typedef struct packed {
		logic [7:0] character;
		logic is_last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] answer;
		logic [2:0] error_code;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load_item;   // capture the accepted item
		logic lit_step;    // digit handling
		logic end_lit;     // push pending literal
		logic pop_ops;     // read two operands into operand regs
		logic alu_exec;    // add/sub/mul result push
		logic div_start;
		logic div_step;
		logic div_push;
		logic bad_char;    // latch the bad character error
		logic finish;      // form result
		logic clear;       // reset expression state
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] cclass;
		logic is_last;
		logic err_set;
		logic div_done;
	} dp_sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/pie_datapath.sv
// pie_datapath: operand stack, literal accumulator, ALU and serial divider.
// Depends on pie_pkg.
`default_nettype none
module pie_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire pie_pkg::in_item_t in_item,
	input wire pie_pkg::dp_cmd_t cmd,
	output pie_pkg::dp_sts_t sts,
	output pie_pkg::out_item_t res
);
	localparam int W = pie_pkg::VALUE_WIDTH;

	logic [W-1:0] stack_q [pie_pkg::STACK_DEPTH];
	logic [pie_pkg::CNT_W-1:0] cnt_q;
	logic [W-1:0] lit_q;
	logic in_lit_q;
	logic [2:0] err_q;
	logic [7:0] ch_q;
	logic last_q;
	logic [W-1:0] lhs_q, rhs_q;
	logic [W-1:0] quo_q, rem_q, dvd_q;
	logic [pie_pkg::DCNT_W-1:0] dcnt_q;
	logic is_mod_q, neg_q;

	// character class
	logic [2:0] cc;
	always_comb begin
		case (ch_q)
			8'h2b: cc = pie_pkg::CC_ADD;
			8'h2d: cc = pie_pkg::CC_SUB;
			8'h2a: cc = pie_pkg::CC_MUL;
			8'h2f: cc = pie_pkg::CC_DIV;
			8'h25: cc = pie_pkg::CC_MOD;
			8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d: cc = pie_pkg::CC_SPACE;
			default: cc = (ch_q >= 8'h30 && ch_q <= 8'h39) ? pie_pkg::CC_DIGIT
				: pie_pkg::CC_BAD;
		endcase
	end

	// literal limit check: acc*10+d <= 2^(W-1)-1
	logic [W-1:0] d;
	logic [W+3:0] lit_next;
	assign d = W'(ch_q - 8'h30);
	assign lit_next = ({4'b0, lit_q} << 3) + ({4'b0, lit_q} << 1) + {4'b0, d};
	logic lit_ovf;
	assign lit_ovf = lit_next > {5'b0, {(W-1){1'b1}}};

	// ALU for + - *
	logic [W-1:0] alu;
	always_comb begin
		case (cc)
			pie_pkg::CC_ADD: alu = lhs_q + rhs_q;
			pie_pkg::CC_SUB: alu = lhs_q - rhs_q;
			default: alu = W'(lhs_q * rhs_q);
		endcase
	end

	logic [W-1:0] ua, ub;
	assign ua = lhs_q[W-1] ? -lhs_q : lhs_q;
	assign ub = rhs_q[W-1] ? -rhs_q : rhs_q;
	logic [W:0] trial;
	assign trial = {rem_q, dvd_q[W-1]} - {1'b0, ub};

	logic full;
	assign full = cnt_q == pie_pkg::CNT_W'(pie_pkg::STACK_DEPTH);
	logic [pie_pkg::SP_W-1:0] top_idx;
	assign top_idx = cnt_q[pie_pkg::SP_W-1:0];

	// push helper value
	logic push_en;
	logic [W-1:0] push_val;
	always_comb begin
		push_en = 1'b0;
		push_val = lit_q;
		if (cmd.end_lit && in_lit_q && err_q == pie_pkg::ERR_NONE) push_en = 1'b1;
		if (cmd.alu_exec) begin
			push_en = 1'b1;
			push_val = alu;
		end
		if (cmd.div_push) begin
			push_en = 1'b1;
			push_val = is_mod_q ? (neg_q ? -rem_q : rem_q) : (neg_q ? -quo_q : quo_q);
		end
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (push_en && !full) stack_q[top_idx] <= push_val;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			ch_q <= in_item.character;
			last_q <= in_item.is_last;
		end
		if (cmd.pop_ops) begin
			rhs_q <= stack_q[pie_pkg::SP_W'(cnt_q - 1'b1)];
			lhs_q <= stack_q[pie_pkg::SP_W'(cnt_q - 2'd2)];
		end
		if (cmd.div_start) begin
			dvd_q <= ua;
			rem_q <= '0;
			quo_q <= '0;
			is_mod_q <= cc == pie_pkg::CC_MOD;
			neg_q <= (cc == pie_pkg::CC_MOD) ? lhs_q[W-1] : (lhs_q[W-1] ^ rhs_q[W-1]);
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], dvd_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	// control state of the expression
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			lit_q <= '0;
			in_lit_q <= 1'b0;
			err_q <= pie_pkg::ERR_NONE;
			dcnt_q <= '0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
			lit_q <= '0;
			in_lit_q <= 1'b0;
			err_q <= pie_pkg::ERR_NONE;
		end else begin
			if (cmd.lit_step) begin
				if (!in_lit_q) begin
					in_lit_q <= 1'b1;
					lit_q <= d;
				end else if (lit_ovf) err_q <= pie_pkg::ERR_LIT;
				else lit_q <= lit_next[W-1:0];
			end
			if (cmd.end_lit && in_lit_q) begin
				in_lit_q <= 1'b0;
				lit_q <= '0;
			end
			if (push_en) begin
				if (full) err_q <= pie_pkg::ERR_FULL;
				else cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.pop_ops) begin
				if (cnt_q < pie_pkg::CNT_W'(2)) err_q <= pie_pkg::ERR_UNDER;
				else cnt_q <= cnt_q - pie_pkg::CNT_W'(2);
			end
			if (cmd.bad_char) err_q <= pie_pkg::ERR_CHAR;
			if (cmd.div_start) begin
				dcnt_q <= pie_pkg::DCNT_W'(W);
				if (rhs_q == '0) err_q <= pie_pkg::ERR_DIVZ;
			end else if (cmd.div_step) dcnt_q <= dcnt_q - 1'b1;
		end
	end

	// result forming
	always_comb begin
		res.answer = '0;
		res.error_code = err_q;
		if (err_q == pie_pkg::ERR_NONE) begin
			if (cnt_q == '0) res.error_code = pie_pkg::ERR_EMPTY;
			else if (cnt_q != pie_pkg::CNT_W'(1)) res.error_code = pie_pkg::ERR_LEFT;
			else res.answer = 32'(signed'(stack_q[0]));
		end
	end

	assign sts.cclass = cc;
	assign sts.is_last = last_q;
	assign sts.err_set = err_q != pie_pkg::ERR_NONE;
	assign sts.div_done = dcnt_q == pie_pkg::DCNT_W'(1);
endmodule
`default_nettype wire

>>> hw/rtl/pie_ctrl.sv
// pie_ctrl: sequencer for one character: decode, pop, execute, divide, finish.
// Depends on pie_pkg.
`default_nettype none
module pie_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	output pie_pkg::dp_cmd_t cmd,
	input wire pie_pkg::dp_sts_t sts,
	input wire pie_pkg::out_item_t res,
	output pie_pkg::out_item_t out_data
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_OP = 3'd2;
	localparam logic [2:0] S_EXEC = 3'd3;
	localparam logic [2:0] S_DIV = 3'd4;
	localparam logic [2:0] S_PUSH = 3'd5;
	localparam logic [2:0] S_LAST = 3'd6;
	localparam logic [2:0] S_FIN = 3'd7;

	logic [2:0] state_q, state_d;
	logic ovalid_q;
	logic is_div;
	assign is_div = sts.cclass == pie_pkg::CC_DIV || sts.cclass == pie_pkg::CC_MOD;

	assign in_stall = state_q != S_IDLE;
	assign out_valid = ovalid_q;

	// next state and commands
	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.load_item = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				state_d = sts.is_last ? S_LAST : S_IDLE;
				if (!sts.err_set) begin
					if (sts.cclass == pie_pkg::CC_DIGIT) cmd.lit_step = 1'b1;
					else begin
						cmd.end_lit = 1'b1;
						if (sts.cclass != pie_pkg::CC_SPACE) state_d = S_OP;
					end
				end
			end
			S_OP: begin
				// literal push may have raised stack full
				state_d = sts.is_last ? S_LAST : S_IDLE;
				if (!sts.err_set) begin
					if (sts.cclass == pie_pkg::CC_BAD) cmd.bad_char = 1'b1;
					else begin
						cmd.pop_ops = 1'b1;
						state_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				state_d = sts.is_last ? S_LAST : S_IDLE;
				if (!sts.err_set) begin
					if (is_div) begin
						cmd.div_start = 1'b1;
						state_d = S_DIV;
					end else cmd.alu_exec = 1'b1;
				end
			end
			S_DIV: begin
				if (sts.err_set) state_d = sts.is_last ? S_LAST : S_IDLE;
				else begin
					cmd.div_step = 1'b1;
					if (sts.div_done) state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				cmd.div_push = 1'b1;
				state_d = sts.is_last ? S_LAST : S_IDLE;
			end
			S_LAST: begin
				cmd.end_lit = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				// wait here while the previous result is still held
				if (!ovalid_q || !out_stall) begin
					cmd.finish = 1'b1;
					cmd.clear = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) ovalid_q <= 1'b1;
			else if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) out_data <= res;
	end
endmodule
`default_nettype wire

>>> hw/rtl/postfix_integer_evaluator.sv
// postfix_integer_evaluator: top level joining controller and datapath.
// Depends on pie_pkg, pie_ctrl, pie_datapath.
//
// channel  dir  payload              handshake
// in       in   pie_pkg::in_item_t   in_valid / in_stall
// out      out  pie_pkg::out_item_t  out_valid / out_stall
//
// Digits and spaces pass decode only, bad characters also the op step,
// + - * also execute; / and % divide serially, then push the result.
// A zero divisor skips the push; a last char adds the finish steps.
// Reset clears all control state; the stack needs no clearing.
// A waiting result holds the block in its finish step until taken.
`default_nettype none
module postfix_integer_evaluator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire pie_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output pie_pkg::out_item_t out_data
);
	pie_pkg::dp_cmd_t cmd;
	pie_pkg::dp_sts_t sts;
	pie_pkg::out_item_t res;

	pie_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts),
		.res(res), .out_data(out_data)
	);

	pie_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cmd(cmd), .sts(sts), .res(res)
	);
endmodule
`default_nettype wire

>>> hw/rtl/pie_checker.sv
// pie_checker: port-level assertions for postfix_integer_evaluator, with bind.
// Depends on pie_pkg.
`default_nettype none
module pie_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire pie_pkg::out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code != pie_pkg::ERR_NONE |-> out_data.answer == '0)
		else $error("nonzero answer with error");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken on consecutive cycles");
endmodule

bind postfix_integer_evaluator pie_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
